// File: rtl/sil_pkg.sv
// Shared types and constants for the serial image loader.
// No dependencies; imported by every module of the loader.
`timescale 1ns / 1ps
`default_nettype none

package sil_pkg;

   localparam int unsigned HEADER_DIGITS = 4;

   localparam logic [31:0] LOAD_BASE_RESET  = 32'h0008_0000;
   localparam logic [13:0] MIN_LENGTH_RESET = 14'd64;
   localparam logic [13:0] MAX_LENGTH_RESET = 14'd10000;

   localparam logic [7:0] ASCII_ZERO = 8'h30;
   localparam logic [7:0] ASCII_NINE = 8'h39;

   localparam logic [1:0] CSR_LOAD_BASE  = 2'd0;
   localparam logic [1:0] CSR_MIN_LENGTH = 2'd1;
   localparam logic [1:0] CSR_MAX_LENGTH = 2'd2;

   localparam logic [1:0] PH_HEADER  = 2'd0;
   localparam logic [1:0] PH_PAYLOAD = 2'd1;
   localparam logic [1:0] PH_DONE    = 2'd2;

   localparam logic [2:0] K_IGNORED = 3'd0;
   localparam logic [2:0] K_DIGIT   = 3'd1;
   localparam logic [2:0] K_ACCEPT  = 3'd2;
   localparam logic [2:0] K_REJECT  = 3'd3;
   localparam logic [2:0] K_WRITE   = 3'd4;
   localparam logic [2:0] K_IDLE    = 3'd5;

   typedef struct packed {
      logic [31:0] load_base;
      logic [13:0] min_length;
      logic [13:0] max_length;
   } cfg_type;

   typedef struct packed {
      logic [2:0]  event_kind;
      logic [31:0] write_address;
      logic [7:0]  write_data;
      logic [13:0] length_value;
      logic        last_byte;
   } rsp_type;

endpackage

`default_nettype wire

// File: rtl/sil_csr.sv
// Configuration registers of the serial image loader.
// Depends on sil_pkg for register indexes, reset values and cfg_type.
`timescale 1ns / 1ps
`default_nettype none

module sil_csr (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_we,
   input  wire logic [1:0]       csr_index,
   input  wire logic [31:0]      csr_wdata,
   output sil_pkg::cfg_type      cfg
);
   import sil_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_LOAD_BASE:  cfg_in.load_base  = csr_wdata;
            CSR_MIN_LENGTH: cfg_in.min_length = csr_wdata[13:0];
            CSR_MAX_LENGTH: cfg_in.max_length = csr_wdata[13:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.load_base  <= LOAD_BASE_RESET;
         cfg_ff.min_length <= MIN_LENGTH_RESET;
         cfg_ff.max_length <= MAX_LENGTH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// File: rtl/sil_step.sv
// Input register, loader state and per-word decode of the serial image loader.
// Depends on sil_pkg for phase and kind codes, cfg_type and rsp_type.
`timescale 1ns / 1ps
`default_nettype none

module sil_step (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire logic [7:0]       in_byte,
   input  sil_pkg::cfg_type      cfg,
   output logic                  res_valid,
   input  wire logic             res_ready,
   output sil_pkg::rsp_type      res
);
   import sil_pkg::*;

   localparam logic [2:0] DIGITS = 3'(HEADER_DIGITS);

   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   logic [1:0]  phase_ff,     phase_in;
   logic [1:0]  digits_ff,    digits_in;
   logic [13:0] acc_ff,       acc_in;
   logic [13:0] remaining_ff, remaining_in;
   logic [31:0] addr_ff,      addr_in;

   logic        fire;
   logic        is_digit;
   logic [16:0] acc_wide;
   logic [13:0] acc_next;
   rsp_type     res_c;

   assign fire     = in_valid_ff && res_ready;
   assign in_ready = !in_valid_ff || res_ready;
   assign is_digit = (in_byte_ff >= ASCII_ZERO) && (in_byte_ff <= ASCII_NINE);
   assign acc_wide = {acc_ff, 3'b000} + {2'b00, acc_ff, 1'b0}
                     + {13'd0, 4'(in_byte_ff - ASCII_ZERO)};
   assign acc_next = acc_wide[13:0];

   always_comb begin
      res_c        = '0;
      phase_in     = phase_ff;
      digits_in    = digits_ff;
      acc_in       = acc_ff;
      remaining_in = remaining_ff;
      addr_in      = addr_ff;
      unique case (phase_ff)
         PH_HEADER: begin
            res_c.event_kind = K_IGNORED;
            if (is_digit) begin
               res_c.write_data = in_byte_ff;
               if (({1'b0, digits_ff} + 3'd1) >= DIGITS) begin
                  res_c.length_value = acc_next;
                  digits_in          = 2'd0;
                  acc_in             = 14'd0;
                  if ((acc_next < cfg.min_length) || (acc_next > cfg.max_length)) begin
                     res_c.event_kind = K_REJECT;
                  end else begin
                     res_c.event_kind = K_ACCEPT;
                     remaining_in     = acc_next;
                     addr_in          = cfg.load_base;
                     phase_in         = (acc_next == 14'd0) ? PH_DONE : PH_PAYLOAD;
                  end
               end else begin
                  res_c.event_kind = K_DIGIT;
                  digits_in        = digits_ff + 2'd1;
                  acc_in           = acc_next;
               end
            end
         end
         PH_PAYLOAD: begin
            res_c.event_kind    = K_WRITE;
            res_c.write_address = addr_ff;
            res_c.write_data    = in_byte_ff;
            addr_in             = addr_ff + 32'd1;
            if (remaining_ff <= 14'd1) begin
               res_c.last_byte = 1'b1;
               remaining_in    = 14'd0;
               phase_in        = PH_DONE;
            end else begin
               remaining_in = remaining_ff - 14'd1;
            end
         end
         default: begin
            res_c.event_kind = K_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         phase_ff     <= PH_HEADER;
         digits_ff    <= 2'd0;
         acc_ff       <= 14'd0;
         remaining_ff <= 14'd0;
         addr_ff      <= LOAD_BASE_RESET;
      end else begin
         if (in_ready) begin
            in_valid_ff <= in_valid;
         end
         if (fire) begin
            phase_ff     <= phase_in;
            digits_ff    <= digits_in;
            acc_ff       <= acc_in;
            remaining_ff <= remaining_in;
            addr_ff      <= addr_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         in_byte_ff <= in_byte;
      end
   end

   assign res_valid = in_valid_ff;
   assign res       = res_c;

endmodule

`default_nettype wire

// File: rtl/sil_rsp_reg.sv
// Result register of the serial image loader; holds one word toward the receiver.
// Depends on sil_pkg for rsp_type.
`timescale 1ns / 1ps
`default_nettype none

module sil_rsp_reg (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  sil_pkg::rsp_type      in_rsp,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output sil_pkg::rsp_type      out_rsp
);
   import sil_pkg::*;

   logic    valid_ff;
   rsp_type rsp_ff;

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         rsp_ff <= in_rsp;
      end
   end

   assign out_valid = valid_ff;
   assign out_rsp   = rsp_ff;

endmodule

`default_nettype wire

// File: rtl/serial_image_loader_core.sv
// Serial image loader: decimal length header followed by an addressed payload.
// Channels: req_ (one received byte per word), rsp_ (one event per word),
// csr_ (register write port). Registers: 0 load base, 1 min length, 2 max length.
// Every request word yields exactly one response word. Header digits build a
// four-digit decimal length; a length within bounds starts the payload, whose
// bytes leave as writes with an address counting up from the load base, the
// last one marked by rsp_tlast. After the payload every word reports idle.
// Each word passes the input register, then the result register. One word is taken
// per cycle while the receiver keeps rsp_tready high, since the decode of a byte is
// a single pass with a times-ten add. The two registers form a two-word pipeline
// with ready passed straight back; when the receiver stalls, the result register
// holds its word, the input register takes at most one more, and req_tready stays
// low until rsp_tready returns high.
// Reset clears the phase to header, the length counters and both valid bits, and
// restores the register defaults; it produces no word but drops any it holds or takes.
// Write registers only while no words are in flight.
// Depends on sil_pkg, sil_csr, sil_step and sil_rsp_reg.
`timescale 1ns / 1ps
`default_nettype none

module serial_image_loader_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [55:0]      rsp_tdata,   // [31:0] write_address, [39:32] write_data,
                                         // [53:40] length_value, [55:54] zero
   output logic [2:0]       rsp_tuser,   // [2:0] event_kind
   output logic             rsp_tlast,   // last_byte
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);
   import sil_pkg::*;

   cfg_type cfg;
   rsp_type step_rsp;
   rsp_type out_rsp;
   logic    step_valid;
   logic    step_ready;

   sil_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   sil_step u_step (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_byte   (req_tdata),
      .cfg       (cfg),
      .res_valid (step_valid),
      .res_ready (step_ready),
      .res       (step_rsp)
   );

   sil_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (step_valid),
      .in_ready  (step_ready),
      .in_rsp    (step_rsp),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_rsp   (out_rsp)
   );

   assign rsp_tdata = {2'b00, out_rsp.length_value, out_rsp.write_data,
                       out_rsp.write_address};
   assign rsp_tuser = out_rsp.event_kind;
   assign rsp_tlast = out_rsp.last_byte;

   a_last_only_on_write: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser == K_WRITE)
      else $error("last flag on a non-write word");

   a_kind_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser <= K_IDLE)
      else $error("event kind out of range");

   a_idle_no_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == K_IDLE || rsp_tuser == K_IGNORED) |-> rsp_tdata == 56'd0)
      else $error("payload fields set on an idle or ignored word");

   a_quiet_after_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid)
      else $error("response word right after reset");

endmodule

`default_nettype wire
